// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define FBPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/fbpa_pkg.sv =====
// Shared types and constants of the fixed block pool allocator.
// No dependencies.
package fbpa_pkg;

    localparam int MAX_CELLS = 64;
    localparam int IDX_W     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);

    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int COUNT_W    = 7;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [SIZE_W-1:0]  CELL_SIZE_RST  = 16'd16;
    localparam logic [COUNT_W-1:0] CELL_COUNT_RST = 7'd64;
    localparam logic [ADDR_W-1:0]  BASE_ADDR_RST  = 32'd0;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_FULL      = 2'd1,
        ST_FREED     = 2'd2,
        ST_NOMATCH   = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_SIZE  = 2'd0,
        CFG_CELL_COUNT = 2'd1,
        CFG_BASE_ADDR  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } t_state;

    // sequencer -> walker
    typedef struct packed {
        logic start;
        logic step;
    } t_walk_ctl;

    // walker -> sequencer; nxt_idx is the walker's next index and addresses the registered map read
    typedef struct packed {
        logic [CNT_W-1:0]  idx;
        logic [CNT_W-1:0]  nxt_idx;
        logic [ADDR_W-1:0] addr;
        logic              at_end;
        logic              match;
    } t_walk_sts;

endpackage

// ===== hw/rtl/fbpa_req_if.sv =====
// Request channel: valid/ready handshake carrying one allocate or free request.
// Depends on fbpa_pkg.
interface fbpa_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [fbpa_pkg::ADDR_W-1:0] free_address;

    modport source (output valid, output req_type, output free_address, input ready);
    modport sink   (input valid, input req_type, input free_address, output ready);
endinterface

// ===== hw/rtl/fbpa_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one status and cell address.
// Depends on fbpa_pkg.
interface fbpa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [fbpa_pkg::ADDR_W-1:0] cell_address;

    modport source (output valid, output status, output cell_address, input ready);
    modport sink   (input valid, input status, input cell_address, output ready);
endinterface

// ===== hw/rtl/fbpa_cell_map.sv =====
// Occupancy map: one taken bit per cell in a memory, cleared by a pass after reset,
// one registered read port and one write port. Depends on fbpa_pkg.
module fbpa_cell_map (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [fbpa_pkg::IDX_W-1:0] i_rd_idx,
    input  logic [fbpa_pkg::IDX_W-1:0] i_wr_idx,
    input  logic                       i_set,
    input  logic                       i_clr,
    output logic                       o_taken,
    output logic                       o_clearing
);

    logic                       r_taken [fbpa_pkg::MAX_CELLS];
    logic                       r_rd_taken;
    logic                       r_clr_busy;
    logic [fbpa_pkg::IDX_W-1:0] r_clr_idx;

    // clearing pass: one cell per cycle over all MAX_CELLS cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == fbpa_pkg::IDX_W'(fbpa_pkg::MAX_CELLS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_taken[r_clr_idx] <= 1'b0;
        end else if (i_set) begin
            r_taken[i_wr_idx] <= 1'b1;
        end else if (i_clr) begin
            r_taken[i_wr_idx] <= 1'b0;
        end
        r_rd_taken <= r_taken[i_rd_idx];
    end

    assign o_taken    = r_rd_taken;
    assign o_clearing = r_clr_busy;

endmodule

// ===== hw/rtl/fbpa_walker.sv =====
// Cell walker: index counter plus the shared address adder and comparator.
// Steps one cell per cycle while i_ctl.step is high; depends on fbpa_pkg.
module fbpa_walker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fbpa_pkg::t_walk_ctl         i_ctl,
    input  logic [fbpa_pkg::ADDR_W-1:0] i_base,
    input  logic [fbpa_pkg::SIZE_W-1:0] i_size,
    input  logic [fbpa_pkg::CNT_W-1:0]  i_cells,
    input  logic [fbpa_pkg::ADDR_W-1:0] i_free_addr,
    output fbpa_pkg::t_walk_sts         o_sts
);

    logic [fbpa_pkg::CNT_W-1:0]  r_idx;
    logic [fbpa_pkg::CNT_W-1:0]  n_idx;
    logic [fbpa_pkg::ADDR_W-1:0] r_addr;
    logic [fbpa_pkg::ADDR_W-1:0] n_addr;
    logic [fbpa_pkg::ADDR_W-1:0] r_target;

    always_comb begin
        n_idx  = r_idx;
        n_addr = r_addr;
        if (i_ctl.start) begin
            n_idx  = '0;
            n_addr = i_base;
        end else if (i_ctl.step) begin
            n_idx  = r_idx + 1'b1;
            // start of next cell, wraps mod 2^32
            n_addr = r_addr + {{(fbpa_pkg::ADDR_W - fbpa_pkg::SIZE_W){1'b0}}, i_size};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (i_ctl.start) begin
            r_target <= i_free_addr;
        end
    end

    assign o_sts.idx     = r_idx;
    assign o_sts.nxt_idx = n_idx;
    assign o_sts.addr    = r_addr;
    assign o_sts.at_end  = (r_idx >= i_cells);
    assign o_sts.match   = (r_addr == r_target);

endmodule

// ===== hw/rtl/fixed_block_pool_allocator_unit.sv =====
// Top level of the fixed block pool allocator: config registers, sequencer,
// response register. Uses fbpa_pkg, fbpa_req_if, fbpa_rsp_if, fbpa_walker,
// fbpa_cell_map and assert_macros.svh.
//
//  channel   dir  handshake          payload
//  i_req     in   valid/ready        req_type, free_address
//  o_rsp     out  valid/ready        status, cell_address
//  i_cfg_*   in   i_cfg_we only      i_cfg_idx, i_cfg_wdata
//
// A request is taken in idle, then the walker visits one cell per cycle from cell 0
// and stops at the first hit or at the end of the n cells in use; a full pool or
// unmatched free walks all n. The walker's single adder/comparator sets this pace.
// After reset a clearing pass opens one cell per cycle; i_req.ready stays low until
// that pass ends. A finished result waits in the walk state while a stalled sink
// holds the response register; i_req.ready is high only in idle.
module fixed_block_pool_allocator_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fbpa_req_if.sink                        i_req,
    fbpa_rsp_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

`include "assert_macros.svh"

    // configuration registers
    logic [fbpa_pkg::SIZE_W-1:0]  r_cell_size;
    logic [fbpa_pkg::COUNT_W-1:0] r_cell_count;
    logic [fbpa_pkg::ADDR_W-1:0]  r_base_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size  <= fbpa_pkg::CELL_SIZE_RST;
            r_cell_count <= fbpa_pkg::CELL_COUNT_RST;
            r_base_addr  <= fbpa_pkg::BASE_ADDR_RST;
        end else if (i_cfg_we) begin
            case (fbpa_pkg::t_cfg_idx'(i_cfg_idx))
                fbpa_pkg::CFG_CELL_SIZE: begin
                    r_cell_size <= i_cfg_wdata[fbpa_pkg::SIZE_W-1:0];
                end
                fbpa_pkg::CFG_CELL_COUNT: begin
                    r_cell_count <= i_cfg_wdata[fbpa_pkg::COUNT_W-1:0];
                end
                fbpa_pkg::CFG_BASE_ADDR: begin
                    r_base_addr <= i_cfg_wdata[fbpa_pkg::ADDR_W-1:0];
                end
                default: begin
                    // unused index: write dropped
                end
            endcase
        end
    end

    // cells in use, count saturates at the built maximum
    logic [fbpa_pkg::CNT_W-1:0] w_cells;
    assign w_cells = (int'(r_cell_count) > fbpa_pkg::MAX_CELLS)
                   ? fbpa_pkg::CNT_W'(fbpa_pkg::MAX_CELLS)
                   : fbpa_pkg::CNT_W'(r_cell_count);

    // sequencer
    fbpa_pkg::t_state    r_state;
    fbpa_pkg::t_state    n_state;
    fbpa_pkg::t_req      r_req_type;
    fbpa_pkg::t_walk_ctl w_ctl;
    fbpa_pkg::t_walk_sts w_sts;

    logic w_accept;
    logic w_taken;
    logic w_clearing;
    logic w_hit;
    logic w_finish;
    logic w_out_free;
    logic w_load;
    logic w_is_alloc;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_is_alloc = (r_req_type == fbpa_pkg::REQ_ALLOC);
    // allocate stops at the first open cell, free at the first address match
    assign w_hit      = w_is_alloc ? !w_taken : w_sts.match;
    assign w_finish   = w_sts.at_end || w_hit;
    assign w_out_free = !o_rsp.valid || o_rsp.ready;
    assign w_load     = (r_state == fbpa_pkg::S_WALK) && w_finish && w_out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            fbpa_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = fbpa_pkg::S_WALK;
                end
            end
            fbpa_pkg::S_WALK: begin
                if (w_load) begin
                    n_state = fbpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fbpa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        i_req.ready = (r_state == fbpa_pkg::S_IDLE) && !w_clearing;
        w_ctl.start = w_accept;
        w_ctl.step  = (r_state == fbpa_pkg::S_WALK) && !w_finish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbpa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type <= fbpa_pkg::t_req'(i_req.req_type);
        end
    end

    fbpa_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_base      (r_base_addr),
        .i_size      (r_cell_size),
        .i_cells     (w_cells),
        .i_free_addr (i_req.free_address),
        .o_sts       (w_sts)
    );

    // map is read through its register at the walker's next index, so the taken bit
    // of the current cell is ready in the cycle the walker sits on it;
    // map update happens only when the result transfers into the response register
    fbpa_cell_map u_cell_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (w_sts.nxt_idx[fbpa_pkg::IDX_W-1:0]),
        .i_wr_idx   (w_sts.idx[fbpa_pkg::IDX_W-1:0]),
        .i_set      (w_load && w_is_alloc && !w_sts.at_end),
        .i_clr      (w_load && !w_is_alloc && !w_sts.at_end),
        .o_taken    (w_taken),
        .o_clearing (w_clearing)
    );

    // result encoding
    fbpa_pkg::t_status           w_status;
    logic [fbpa_pkg::ADDR_W-1:0] w_addr;

    always_comb begin
        if (w_sts.at_end) begin
            w_status = w_is_alloc ? fbpa_pkg::ST_FULL : fbpa_pkg::ST_NOMATCH;
            w_addr   = '0;
        end else begin
            w_status = w_is_alloc ? fbpa_pkg::ST_ALLOCATED : fbpa_pkg::ST_FREED;
            w_addr   = w_is_alloc ? w_sts.addr : '0;
        end
    end

    // response register
    logic                        r_rsp_valid;
    logic [1:0]                  r_rsp_status;
    logic [fbpa_pkg::ADDR_W-1:0] r_rsp_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_load) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rsp_status <= w_status;
            r_rsp_addr   <= w_addr;
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.status       = r_rsp_status;
    assign o_rsp.cell_address = r_rsp_addr;

    // checks
    `FBPA_ASSERT(a_walk_in_range,
        (r_state == fbpa_pkg::S_WALK) |-> (w_sts.idx <= w_cells),
        "walker ran past the cells in use")
    `FBPA_ASSERT(a_alloc_takes_open_cell,
        (w_load && (w_status == fbpa_pkg::ST_ALLOCATED)) |-> !w_taken,
        "allocated cell was already taken")
    `FBPA_ASSERT_NEXT(a_rsp_held,
        o_rsp.valid && !o_rsp.ready,
        o_rsp.valid && $stable(o_rsp.status) && $stable(o_rsp.cell_address),
        "response changed while the sink stalled")
    `FBPA_ASSERT(a_addr_zero_unless_alloc,
        (o_rsp.valid && (o_rsp.status != fbpa_pkg::ST_ALLOCATED)) |-> (o_rsp.cell_address == '0),
        "nonzero address on a result without allocation")

endmodule
